// ===== rtl/mbg_pkg.sv =====
// Shared types and constants for the maze backtracker generator.
// No dependencies.
`timescale 1ns / 1ps
package mbg_pkg;
  localparam int unsigned LcgMul = 32'd1103515245;
  localparam int unsigned LcgAdd = 32'd12345;

  localparam logic KIND_GEN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Direction codes: 0 = +2 col, 1 = -2 col, 2 = +2 row, 3 = -2 row
  typedef logic [1:0] dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SHUF,
    ST_OPEN,
    ST_PUSH,
    ST_RD_TOP,
    ST_EVAL,
    ST_CHECK,
    ST_CARVE,
    ST_DONE,
    ST_QRD,
    ST_QOUT
  } state_t;

  // Keep only the low 32 bits of the product
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    begin
      lcg_next = s * LcgMul + LcgAdd;
    end
  endfunction
endpackage

// ===== rtl/mbg_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mbg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/maze_backtracker_generator_unit.sv =====
// Maze backtracker generator: grid and walk stack in RAM, one sequencer.
// Depends on mbg_pkg and mbg_ram.
// Sequence: a query reads the grid row, then registers the result. A generate
//   clears the grid rows, then shuffles, opens and pushes each carved cell;
//   off-grid or already-opened neighbours are skipped; a spent frame is popped.
// Throughput: one request at a time; the next is taken once the result leaves.
// Reset: rst_n synchronous; seed and random state to one, stack empty; the
//   grid RAM is swept to all walls by a clearing pass over every grid row.
`timescale 1ns / 1ps
module maze_backtracker_generator_unit
  import mbg_pkg::*;
#(
  parameter int MAZE_WIDTH  = 63,
  parameter int MAZE_HEIGHT = 31,
  parameter int STACK_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [5:0]  in_row,
  input  logic [6:0]  in_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_cell_is_wall,
  output logic        out_generate_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int GridH = MAZE_HEIGHT + 2;
  localparam int GridW = MAZE_WIDTH + 2;
  localparam int RowAw = $clog2(GridH);
  localparam int ColW  = $clog2(GridW + 1);
  localparam int SpAw  = $clog2(STACK_DEPTH);
  localparam int SpW   = SpAw + 1;
  // Frame: row, col, four direction codes, next index (0..4)
  localparam int FrW   = RowAw + ColW + 8 + 3;

  state_t state_r, state_nxt;
  logic [31:0] seed_r, rnd_r, rnd_nxt;
  logic [SpW-1:0] sp_r, sp_nxt;
  logic [RowAw-1:0] clr_r, clr_nxt;
  logic [1:0] si_r, si_nxt;
  logic [7:0] ord_r, ord_nxt;
  logic [RowAw-1:0] cy_r, cy_nxt, ny_r, ny_nxt;
  logic [ColW-1:0] cx_r, cx_nxt, nx_r, nx_nxt;
  logic [2:0] nidx_r, nidx_nxt;
  logic [GridW-1:0] row_buf_r, row_buf_nxt;
  logic out_valid_r, out_valid_nxt, out_wall_r, out_wall_nxt, out_done_r, out_done_nxt;
  logic [5:0] q_row_r, q_row_nxt;
  logic [6:0] q_col_r, q_col_nxt;
  logic init_r, init_nxt;

  // Grid RAM
  logic g_we;
  logic [RowAw-1:0] g_waddr, g_raddr;
  logic [GridW-1:0] g_wdata, g_rdata;
  // Stack RAM
  logic s_we;
  logic [SpAw-1:0] s_waddr, s_raddr;
  logic [FrW-1:0] s_wdata, s_rdata;

  mbg_ram #(.Width(GridW), .Depth(GridH)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata));
  mbg_ram #(.Width(FrW), .Depth(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 32'd0 : seed_r;

  // Hold off requests until the clearing pass after reset has finished
  assign in_ready = (state_r == ST_IDLE) && init_r && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_cell_is_wall = out_wall_r;
  assign out_generate_done = out_done_r;

  // Unpack popped frame
  logic [RowAw-1:0] f_cy;
  logic [ColW-1:0] f_cx;
  logic [7:0] f_ord;
  logic [2:0] f_nidx;
  assign {f_cy, f_cx, f_ord, f_nidx} = s_rdata;

  dir_t cur_dir;
  logic [1:0] j;
  logic [7:0] swapped;
  logic signed [ColW+1:0] tx;
  logic signed [RowAw+1:0] ty;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    sp_nxt = sp_r;
    clr_nxt = clr_r;
    si_nxt = si_r;
    ord_nxt = ord_r;
    cy_nxt = cy_r; cx_nxt = cx_r; ny_nxt = ny_r; nx_nxt = nx_r;
    nidx_nxt = nidx_r;
    row_buf_nxt = row_buf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_wall_nxt = out_wall_r;
    out_done_nxt = out_done_r;
    q_row_nxt = q_row_r; q_col_nxt = q_col_r;
    init_nxt = init_r;
    g_we = 1'b0; g_waddr = clr_r; g_wdata = '1; g_raddr = cy_r;
    s_we = 1'b0; s_waddr = sp_r[SpAw-1:0]; s_raddr = SpAw'(sp_r - SpW'(1));
    s_wdata = {cy_r, cx_r, ord_r, nidx_r};
    j = rnd_nxt[17:16];
    swapped = ord_r;
    cur_dir = f_ord[2*f_nidx[1:0] +: 2];
    tx = '0; ty = '0;
    case (state_r)
      ST_IDLE: begin
        if (!init_r) begin
          clr_nxt = '0;
          state_nxt = ST_CLEAR;
        end else if (in_valid && in_ready) begin
          if (in_kind == KIND_GEN) begin
            rnd_nxt = seed_r;
            sp_nxt = '0;
            clr_nxt = '0;
            state_nxt = ST_CLEAR;
          end else begin
            q_row_nxt = in_row;
            q_col_nxt = in_col;
            state_nxt = ST_QRD;
          end
        end
      end
      ST_CLEAR: begin
        // Sweep every row to all walls
        g_we = 1'b1;
        g_waddr = clr_r;
        g_wdata = '1;
        clr_nxt = clr_r + RowAw'(1);
        if (clr_r == RowAw'(GridH - 1)) begin
          if (!init_r) begin
            init_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cy_nxt = RowAw'(1);
            cx_nxt = ColW'(1);
            ord_nxt = 8'b11_10_01_00;
            si_nxt = '0;
            state_nxt = ST_SHUF;
          end
        end
      end
      ST_SHUF: begin
        // One swap per cycle: position si with position draw[17:16]
        rnd_nxt = lcg_next(rnd_r);
        j = rnd_nxt[17:16];
        swapped = ord_r;
        swapped[2*si_r +: 2] = ord_r[2*j +: 2];
        swapped[2*j +: 2] = ord_r[2*si_r +: 2];
        ord_nxt = swapped;
        si_nxt = si_r + 2'd1;
        if (si_r == 2'd3) begin
          state_nxt = ST_OPEN;
        end
        g_raddr = cy_r;
      end
      ST_OPEN: begin
        // Row read issued in last shuffle cycle; clear the cell bit
        row_buf_nxt = g_rdata;
        row_buf_nxt[cx_r[$clog2(GridW)-1:0]] = 1'b0;
        g_we = 1'b1;
        g_waddr = cy_r;
        g_wdata = row_buf_nxt;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        s_we = 1'b1;
        s_waddr = sp_r[SpAw-1:0];
        s_wdata = {cy_r, cx_r, ord_r, 3'd0};
        sp_nxt = sp_r + SpW'(1);
        state_nxt = ST_RD_TOP;
      end
      ST_RD_TOP: begin
        if (sp_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          s_raddr = SpAw'(sp_r - SpW'(1));
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (f_nidx[2]) begin
          sp_nxt = sp_r - SpW'(1);
          state_nxt = ST_RD_TOP;
        end else begin
          // Bump next index in place
          s_we = 1'b1;
          s_waddr = SpAw'(sp_r - SpW'(1));
          s_wdata = {f_cy, f_cx, f_ord, f_nidx + 3'd1};
          cy_nxt = f_cy;
          cx_nxt = f_cx;
          tx = $signed({2'b00, f_cx});
          ty = $signed({2'b00, f_cy});
          case (cur_dir)
            2'd0: tx = tx + 3'sd2;
            2'd1: tx = tx - 3'sd2;
            2'd2: ty = ty + 3'sd2;
            default: ty = ty - 3'sd2;
          endcase
          if (tx > 0 && tx < MAZE_WIDTH + 1 && ty > 0 && ty < MAZE_HEIGHT + 1
              && sp_r < SpW'(STACK_DEPTH)) begin
            nx_nxt = ColW'(tx);
            ny_nxt = RowAw'(ty);
            g_raddr = RowAw'(ty);
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_RD_TOP;
          end
        end
      end
      ST_CHECK: begin
        if (g_rdata[nx_r[$clog2(GridW)-1:0]]) begin
          // Read the row holding the wall between the cells
          g_raddr = RowAw'((ny_r + cy_r) >> 1);
          state_nxt = ST_CARVE;
        end else begin
          state_nxt = ST_RD_TOP;
        end
      end
      ST_CARVE: begin
        row_buf_nxt = g_rdata;
        row_buf_nxt[ColW'((nx_r + cx_r) >> 1)] = 1'b0;
        g_we = 1'b1;
        g_waddr = RowAw'((ny_r + cy_r) >> 1);
        g_wdata = row_buf_nxt;
        cy_nxt = ny_r;
        cx_nxt = nx_r;
        ord_nxt = 8'b11_10_01_00;
        si_nxt = '0;
        state_nxt = ST_SHUF;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_wall_nxt = 1'b0;
        out_done_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_QRD: begin
        g_raddr = RowAw'(q_row_r);
        state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        out_valid_nxt = 1'b1;
        out_done_nxt = 1'b0;
        if (32'(q_row_r) < GridH && 32'(q_col_r) < GridW) begin
          out_wall_nxt = g_rdata[q_col_r[$clog2(GridW)-1:0]];
        end else begin
          out_wall_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seed_r <= 32'd1;
      rnd_r <= 32'd1;
      sp_r <= '0;
      out_valid_r <= 1'b0;
      init_r <= 1'b0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      sp_r <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      init_r <= init_nxt;
      clr_r <= clr_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
        seed_r <= cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r <= si_nxt;
    ord_r <= ord_nxt;
    cy_r <= cy_nxt; cx_r <= cx_nxt; ny_r <= ny_nxt; nx_r <= nx_nxt;
    nidx_r <= nidx_nxt;
    row_buf_r <= row_buf_nxt;
    out_wall_r <= out_wall_nxt;
    out_done_r <= out_done_nxt;
    q_row_r <= q_row_nxt;
    q_col_r <= q_col_nxt;
  end

  // Stack never exceeds its depth
  assert property (@(posedge clk) disable iff (!rst_n) sp_r <= SpW'(STACK_DEPTH))
    else $error("walk stack overflow");
  // A generate result never reports a wall
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_wall_r)
    else $error("generate result with wall set");
  // A pending result holds while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_done_r))
    else $error("result dropped");
endmodule
